>>> rtl/core/indexed_cv_access_sequencer_defines.svh
// -----------------------------------------------------------------------------
// indexed cv access sequencer assertion macros
// shared concurrent assertion shorthands, clocked on clk_i
// -----------------------------------------------------------------------------
`ifndef INDEXED_CV_ACCESS_SEQUENCER_DEFINES_SVH
`define INDEXED_CV_ACCESS_SEQUENCER_DEFINES_SVH

// checked only while out of reset
`define ICS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define ICS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/ics_pkg.sv
// -----------------------------------------------------------------------------
// ics_pkg
// item types and codes of the indexed cv access sequencer
// -----------------------------------------------------------------------------
package ics_pkg;

  // input item
  typedef struct packed {
    logic [1:0] op;
    logic       index_two_used;
    logic [2:0] partner_status;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0] command;
    logic       busy_res;
    logic       mark_stored;
    logic       idle_event;
  } out_item_t;

  // op codes
  localparam logic [1:0] OP_START_READ    = 2'd0;
  localparam logic [1:0] OP_START_WRITE   = 2'd1;
  localparam logic [1:0] OP_START_CONFIRM = 2'd2;
  localparam logic [1:0] OP_COMPLETION    = 2'd3;

  // command codes
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_PI      = 3'd1;
  localparam logic [2:0] CMD_SI      = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_CONFIRM = 3'd4;
  localparam logic [2:0] CMD_WRITE   = 3'd5;

  // sequence kinds
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_CONFIRM = 2'd2;

  // steps within a sequence
  localparam logic [1:0] STEP_PI_SI   = 2'd0;
  localparam logic [1:0] STEP_PI_ONLY = 2'd1;
  localparam logic [1:0] STEP_SI      = 2'd2;
  localparam logic [1:0] STEP_VAR     = 2'd3;

  // partner status codes
  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SAME   = 3'd2;
  localparam logic [2:0] ST_DIFF   = 3'd3;

  // phase encoding
  localparam logic [3:0] PHASE_IDLE     = 4'd0;
  localparam logic [3:0] PHASE_LAST     = 4'd12;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

endpackage

>>> rtl/core/indexed_cv_access_sequencer.sv
// -----------------------------------------------------------------------------
// indexed_cv_access_sequencer
// steps an indexed decoder-variable access: index writes, access, retries
// -----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_item_i  (ics_pkg::in_item_t)
// out      output     out_valid_o/out_stall_i out_item_o (ics_pkg::out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (retry limit)
//
// one item per cycle while the result is not stalled; input register, then
// result register, with the phase and retry count updated as the item passes
// reset clears phase, retry count and valids; retry limit resets to three
// a stalled result holds the result register and backs up into the input
// register, which then raises in_stall_o
// -----------------------------------------------------------------------------
`include "indexed_cv_access_sequencer_defines.svh"

module indexed_cv_access_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ics_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ics_pkg::out_item_t   out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_data_i
);

  logic               s1_valid_q;
  ics_pkg::in_item_t  s1_item_q;
  logic               out_valid_q;
  ics_pkg::out_item_t out_item_q, out_item_d;
  logic [3:0]         phase_q, phase_d;
  logic [3:0]         retry_cnt_q, retry_cnt_d;
  logic [3:0]         retry_limit_q;
  logic               out_free;
  logic               advance;
  logic               in_accept;
  logic [3:0]         ph_m1;
  logic [1:0]         kind;
  logic [1:0]         step;
  logic               ok;
  logic [2:0]         var_cmd;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign ph_m1 = phase_q - 4'd1;
  assign kind  = ph_m1[3:2];
  assign step  = ph_m1[1:0];

  always_comb begin
    unique case (kind)
      ics_pkg::KIND_READ:    var_cmd = ics_pkg::CMD_READ;
      ics_pkg::KIND_CONFIRM: var_cmd = ics_pkg::CMD_CONFIRM;
      default:               var_cmd = ics_pkg::CMD_WRITE;
    endcase
  end

  always_comb begin
    if (step != ics_pkg::STEP_VAR) begin
      ok = (s1_item_q.partner_status == ics_pkg::ST_STORED);
    end else if (kind == ics_pkg::KIND_READ) begin
      ok = (s1_item_q.partner_status == ics_pkg::ST_READ);
    end else if (kind == ics_pkg::KIND_CONFIRM) begin
      ok = (s1_item_q.partner_status == ics_pkg::ST_SAME) ||
           (s1_item_q.partner_status == ics_pkg::ST_DIFF);
    end else begin
      ok = (s1_item_q.partner_status == ics_pkg::ST_STORED);
    end
  end

  always_comb begin
    phase_d                = phase_q;
    retry_cnt_d            = retry_cnt_q;
    out_item_d.command     = ics_pkg::CMD_NONE;
    out_item_d.mark_stored = 1'b0;
    out_item_d.idle_event  = 1'b0;
    if (s1_item_q.op != ics_pkg::OP_COMPLETION) begin
      // start, abandons any running sequence
      phase_d = {s1_item_q.op, (s1_item_q.index_two_used ? ics_pkg::STEP_PI_SI
                                                          : ics_pkg::STEP_PI_ONLY)} + 4'd1;
      retry_cnt_d        = '0;
      out_item_d.command = ics_pkg::CMD_PI;
    end else if (phase_q == ics_pkg::PHASE_IDLE) begin
      out_item_d.idle_event = 1'b1;
    end else if (phase_q > ics_pkg::PHASE_LAST) begin
      phase_d     = ics_pkg::PHASE_IDLE;
      retry_cnt_d = '0;
    end else if (!ok && (retry_cnt_q < retry_limit_q)) begin
      // retry same step
      retry_cnt_d = retry_cnt_q + 4'd1;
      case (step) inside
        ics_pkg::STEP_PI_SI, ics_pkg::STEP_PI_ONLY: out_item_d.command = ics_pkg::CMD_PI;
        ics_pkg::STEP_SI:                           out_item_d.command = ics_pkg::CMD_SI;
        default:                                    out_item_d.command = var_cmd;
      endcase
    end else begin
      retry_cnt_d = '0;
      case (step) inside
        ics_pkg::STEP_PI_SI: begin
          phase_d            = {kind, ics_pkg::STEP_SI} + 4'd1;
          out_item_d.command = ics_pkg::CMD_SI;
        end
        ics_pkg::STEP_PI_ONLY, ics_pkg::STEP_SI: begin
          phase_d            = {kind, ics_pkg::STEP_VAR} + 4'd1;
          out_item_d.command = var_cmd;
        end
        default: begin
          phase_d                = ics_pkg::PHASE_IDLE;
          out_item_d.mark_stored = (kind == ics_pkg::KIND_WRITE);
        end
      endcase
    end
    out_item_d.busy_res = (phase_d != ics_pkg::PHASE_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= ics_pkg::PHASE_IDLE;
      retry_cnt_q   <= '0;
      retry_limit_q <= ics_pkg::RETRY_LIMIT_RST;
    end else begin
      if (cfg_valid_i) begin
        retry_limit_q <= cfg_data_i;
      end
      if (!s1_valid_q || advance) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance) begin
        phase_q     <= phase_d;
        retry_cnt_q <= retry_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  `ICS_ASSERT(a_phase_legal, phase_q <= ics_pkg::PHASE_LAST, "phase outside its code range")
  `ICS_ASSERT(a_idle_no_retries, (retry_cnt_q != 4'd0) |-> (phase_q != ics_pkg::PHASE_IDLE),
              "retry count left over while idle")
  `ICS_ASSERT(a_stored_ends_seq,
              (out_valid_o && out_item_o.mark_stored) |->
              (out_item_o.command == ics_pkg::CMD_NONE && !out_item_o.busy_res),
              "stored mark on a result that is not the end of a sequence")
  `ICS_ASSERT(a_idle_event_quiet,
              (out_valid_o && out_item_o.idle_event) |->
              (out_item_o.command == ics_pkg::CMD_NONE && !out_item_o.busy_res),
              "idle completion issued a command or left busy set")
  `ICS_ASSERT(a_advance_fills_out, advance |=> out_valid_q,
              "item left the input register without reaching the result register")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// self-checking bench for the indexed cv access sequencer: a queue-fed driver
// pushes start and completion items, mostly as complete access sequences with
// failing steps and abandoned runs mixed in, under random gaps and stalls on
// both sides; every result is checked against an in-bench model of the phase
// and retry counter, with the retry limit changed between drained phases
// -----------------------------------------------------------------------------
module tb;
  import ics_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned MAX_REPORT  = 20;
  localparam int unsigned PHASE_ITEMS = 255;

  typedef enum logic [1:0] {REQ_ITEM, REQ_CFG, REQ_DRAIN} req_kind_e;

  typedef struct {
    req_kind_e  kind;
    in_item_t   item;
    logic [3:0] limit;
  } req_t;

  logic       clk_i;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_item   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [3:0] cfg_data  = '0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_ready;

  req_t        access_q[$];
  out_item_t   due_cmds[$];

  // model state
  logic [3:0]  seq_phase   = PHASE_IDLE;
  logic [3:0]  seq_retries = '0;
  logic [3:0]  retry_lim   = RETRY_LIMIT_RST;

  int unsigned cycles      = 0;
  int unsigned errors      = 0;
  int unsigned n_queued    = 0;
  int unsigned n_sent      = 0;
  int unsigned n_results   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_drains    = 0;
  int unsigned n_retries   = 0;
  int unsigned n_stored    = 0;
  int unsigned n_idle_ev   = 0;
  int unsigned gap_left    = 0;
  int unsigned settle_left = SETTLE;
  int unsigned stall_left  = 0;
  bit          calm_in     = 1'b0;
  bit          calm_out    = 1'b0;

  indexed_cv_access_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
  end

  function automatic int unsigned rand_gap(bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [2:0] access_cmd(logic [1:0] kind);
    if (kind == KIND_READ) return CMD_READ;
    if (kind == KIND_CONFIRM) return CMD_CONFIRM;
    return CMD_WRITE;
  endfunction

  // advances the sequence state by one item and returns the command issued
  function automatic out_item_t next_command(in_item_t it);
    out_item_t  r;
    logic [3:0] p;
    logic [1:0] kind;
    logic [1:0] step;
    logic       ok;
    r = '0;
    r.command = CMD_NONE;
    if (it.op != OP_COMPLETION) begin
      seq_phase = {it.op, it.index_two_used ? STEP_PI_SI : STEP_PI_ONLY} + 4'd1;
      seq_retries = '0;
      r.command = CMD_PI;
    end else if (seq_phase == PHASE_IDLE) begin
      r.idle_event = 1'b1;
    end else if (seq_phase > PHASE_LAST) begin
      seq_phase = PHASE_IDLE;
      seq_retries = '0;
    end else begin
      p = seq_phase - 4'd1;
      kind = p[3:2];
      step = p[1:0];
      if (step != STEP_VAR || kind == KIND_WRITE) begin
        ok = (it.partner_status == ST_STORED);
      end else if (kind == KIND_READ) begin
        ok = (it.partner_status == ST_READ);
      end else begin
        ok = (it.partner_status == ST_SAME) || (it.partner_status == ST_DIFF);
      end
      if (!ok && seq_retries < retry_lim) begin
        seq_retries = seq_retries + 4'd1;
        n_retries++;
        case (step)
          STEP_SI:  r.command = CMD_SI;
          STEP_VAR: r.command = access_cmd(kind);
          default:  r.command = CMD_PI;
        endcase
      end else begin
        seq_retries = '0;
        case (step)
          STEP_PI_SI: begin
            seq_phase = {kind, STEP_SI} + 4'd1;
            r.command = CMD_SI;
          end
          STEP_PI_ONLY, STEP_SI: begin
            seq_phase = {kind, STEP_VAR} + 4'd1;
            r.command = access_cmd(kind);
          end
          default: begin
            seq_phase = PHASE_IDLE;
            r.mark_stored = (kind == KIND_WRITE);
          end
        endcase
      end
    end
    r.busy_res = (seq_phase != PHASE_IDLE);
    return r;
  endfunction

  task automatic add_item(logic [1:0] op, logic two, logic [2:0] status);
    req_t e;
    e.kind = REQ_ITEM;
    e.item.op = op;
    e.item.index_two_used = two;
    e.item.partner_status = status;
    e.limit = '0;
    access_q.push_back(e);
    n_queued++;
  endtask

  task automatic add_ctrl(req_kind_e kind, logic [3:0] limit);
    req_t e;
    e.kind = kind;
    e.item = '0;
    e.limit = limit;
    access_q.push_back(e);
  endtask

  // status that makes the step pass or fail
  function automatic logic [2:0] pick_status(logic [1:0] kind, bit is_var, bit ok);
    logic [2:0] good;
    int unsigned v;
    if (is_var && kind == KIND_CONFIRM) begin
      v = $urandom_range(5);
      if (ok) return $urandom_range(1) ? ST_SAME : ST_DIFF;
      return (v < 2) ? 3'(v) : 3'(v + 2);
    end
    good = (is_var && kind == KIND_READ) ? ST_READ : ST_STORED;
    if (ok) return good;
    return good + 3'($urandom_range(7, 1));
  endfunction

  // one access: start, then per step some failures and usually a success
  task automatic add_sequence(logic [3:0] lim);
    logic [1:0]  kind;
    logic [1:0]  start_op;
    logic        two;
    int unsigned nsteps;
    int unsigned cut;
    int unsigned nf;
    int unsigned r;
    int unsigned s;
    int unsigned f;
    bit          is_var;
    kind = 2'($urandom_range(2));
    start_op = (kind == KIND_READ)  ? OP_START_READ :
               (kind == KIND_WRITE) ? OP_START_WRITE : OP_START_CONFIRM;
    two = 1'($urandom_range(1));
    nsteps = two ? 3 : 2;
    cut = ($urandom_range(9) == 0) ? $urandom_range(nsteps - 1) : nsteps;
    add_item(start_op, two, 3'($urandom_range(7)));
    for (s = 0; s < cut; s++) begin
      is_var = (s == nsteps - 1);
      r = $urandom_range(99);
      if (r < 60) nf = 0;
      else if (r < 85) nf = $urandom_range(lim, 1);
      else nf = lim + 1;
      for (f = 0; f < nf && f <= lim; f++) begin
        add_item(OP_COMPLETION, 1'($urandom_range(1)), pick_status(kind, is_var, 1'b0));
      end
      if (nf <= lim) begin
        add_item(OP_COMPLETION, 1'($urandom_range(1)), pick_status(kind, is_var, 1'b1));
      end
    end
  endtask

  // driver: feeds items and register writes, runs the model on acceptance
  always @(posedge clk_i) begin : feeder
    req_t e;
    logic nv_in;
    logic nv_cfg;
    nv_in = in_valid;
    nv_cfg = cfg_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due_cmds.push_back(next_command(in_item));
        n_sent++;
        nv_in = 1'b0;
        gap_left = rand_gap(calm_in);
        if ($urandom_range(99) == 0) calm_in = !calm_in;
      end
      if (cfg_valid && cfg_ready) begin
        retry_lim = cfg_data;
        n_cfg++;
        nv_cfg = 1'b0;
      end
      if (!nv_in && !nv_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() > 0) begin
          e = access_q[0];
          case (e.kind)
            REQ_ITEM: begin
              nv_in = 1'b1;
              in_item <= e.item;
              void'(access_q.pop_front());
            end
            REQ_CFG: begin
              nv_cfg = 1'b1;
              cfg_data <= e.limit;
              void'(access_q.pop_front());
            end
            default: begin
              if (due_cmds.size() == 0) begin
                if (settle_left == 0) begin
                  settle_left = SETTLE;
                  n_drains++;
                  void'(access_q.pop_front());
                end else begin
                  settle_left--;
                end
              end
            end
          endcase
        end
      end
    end
    in_valid <= nv_in;
    cfg_valid <= nv_cfg;
  end

  // monitor: checks each accepted result, drives random back-pressure
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    logic ns;
    ns = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (due_cmds.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORT) begin
            $display("%0t unexpected result: expected none, actual cmd=%0d busy=%0d stored=%0d idle=%0d",
                     $time, out_item.command, out_item.busy_res, out_item.mark_stored,
                     out_item.idle_event);
          end
        end else begin
          want = due_cmds.pop_front();
          if (want.mark_stored) n_stored++;
          if (want.idle_event) n_idle_ev++;
          if (out_item !== want) begin
            errors++;
            if (errors <= MAX_REPORT) begin
              $display("%0t result mismatch: expected cmd=%0d busy=%0d stored=%0d idle=%0d, actual cmd=%0d busy=%0d stored=%0d idle=%0d",
                       $time, want.command, want.busy_res, want.mark_stored, want.idle_event,
                       out_item.command, out_item.busy_res, out_item.mark_stored,
                       out_item.idle_event);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else if ($urandom_range(3) == 0) begin
        stall_left = rand_gap(calm_out);
      end
      if ($urandom_range(199) == 0) calm_out = !calm_out;
    end
    out_stall <= ns;
  end

  initial begin : run_ctrl
    logic [3:0]  phase_lims[6];
    int unsigned p;
    int unsigned mark;
    bit          timed_out;

    // directed: idle completions, each kind with and without the second
    // index, failures and retry exhaustion, restart while busy
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_START_READ, 1'b1, 3'd7);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b1, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_READ);
    add_item(OP_START_WRITE, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_START_CONFIRM, 1'b1, ST_DIFF);
    add_item(OP_COMPLETION, 1'b0, 3'd4);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b1, 3'd7);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_DIFF);
    add_item(OP_START_CONFIRM, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_SAME);
    add_item(OP_START_READ, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, 3'd4);
    add_item(OP_COMPLETION, 1'b0, 3'd4);
    add_item(OP_COMPLETION, 1'b0, 3'd4);
    add_item(OP_COMPLETION, 1'b0, 3'd4);
    add_item(OP_COMPLETION, 1'b0, ST_READ);
    add_item(OP_START_WRITE, 1'b1, ST_STORED);
    add_item(OP_START_READ, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_STORED);
    add_item(OP_COMPLETION, 1'b0, ST_READ);
    add_item(OP_COMPLETION, 1'b1, 3'd7);

    phase_lims[0] = 4'd15;
    phase_lims[1] = 4'd0;
    phase_lims[2] = 4'd1;
    phase_lims[3] = 4'($urandom_range(14, 4));
    phase_lims[4] = 4'd2;
    phase_lims[5] = 4'($urandom_range(15));
    for (p = 0; p < 6; p++) begin
      add_ctrl(REQ_DRAIN, '0);
      add_ctrl(REQ_CFG, phase_lims[p]);
      mark = n_queued;
      while (n_queued - mark < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          add_item(2'($urandom_range(3)), 1'($urandom_range(1)), 3'($urandom_range(7)));
        end else begin
          add_sequence(phase_lims[p]);
        end
        if ($urandom_range(39) == 0) add_ctrl(REQ_DRAIN, '0);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    while ((access_q.size() != 0 || in_valid || cfg_valid || due_cmds.size() != 0)
           && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
    end
    timed_out = (cycles >= CYCLE_LIMIT);
    if (!timed_out) repeat (2 * SETTLE) @(posedge clk_i);

    $display("tb: %0d items sent, %0d results checked, %0d retry-limit writes, %0d drains",
             n_sent, n_results, n_cfg, n_drains);
    $display("tb: %0d retried commands, %0d writes marked stored, %0d idle completions",
             n_retries, n_stored, n_idle_ev);
    if (!timed_out && errors == 0 && due_cmds.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
